>>> rtl/length_prefixed_message_deframer_top_defines.svh
// assertion macros for the message deframer checker
// no dependencies
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_TOP_DEFINES_SVH

// concurrent check, quiet while reset is asserted
`define LPMD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// concurrent check, also evaluated during reset
`define LPMD_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/lpmd_pkg.sv
// types and constants shared by the message deframer modules
// no dependencies
`timescale 1ns / 1ps

package lpmd_pkg;

    typedef enum logic [2:0] {
        PH_ID    = 3'd0,
        PH_LEN   = 3'd1,
        PH_CHECK = 3'd2,
        PH_MAGIC = 3'd3,
        PH_DATA  = 3'd4
    } t_phase;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] LAST_HDR_BYTE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        last;
        logic [31:0] message_id;
        logic [31:0] message_length;
        logic [31:0] check_value;
    } t_result;

endpackage

>>> rtl/length_prefixed_message_deframer_top.sv
// path: an accepted byte is held in the input register, and its result is then registered in the result register
// throughput: one byte per cycle while the output is not stalled, set by the parser updating on every accepted byte
// header bytes produce no result until the header is finished; a payload byte or a finished header yields at most one
// reset (synchronous, active low) returns to the id phase and clears held words and magic
// top level of the message deframer; depends on lpmd_pkg and the three stage modules
`timescale 1ns / 1ps

module length_prefixed_message_deframer_top
    import lpmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_last,
    output logic [31:0] o_message_id,
    output logic [31:0] o_message_length,
    output logic [31:0] o_check_value
);

    logic       beat_valid;
    logic [7:0] beat_byte;
    logic       can_load;
    logic       adv;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign adv = beat_valid && can_load;

    lpmd_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .o_valid     (beat_valid),
        .o_data_byte (beat_byte),
        .i_take      (adv)
    );

    lpmd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (adv),
        .i_data_byte (beat_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lpmd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res)
    );

    assign o_kind           = out_res.kind;
    assign o_payload_byte   = out_res.payload_byte;
    assign o_last           = out_res.last;
    assign o_message_id     = out_res.message_id;
    assign o_message_length = out_res.message_length;
    assign o_check_value    = out_res.check_value;

endmodule

>>> rtl/lpmd_in_stage.sv
// input register for incoming stream beats
// depends on nothing but the clock and reset
`timescale 1ns / 1ps

module lpmd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    output logic [7:0] o_data_byte,
    input  logic       i_take
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready     = !r_valid || i_take;
    assign o_valid     = r_valid;
    assign o_data_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_data_byte;
        end
    end

endmodule

>>> rtl/lpmd_parser.sv
// header assembly, magic check and payload count for one beat
// depends on lpmd_pkg
`timescale 1ns / 1ps

module lpmd_parser
    import lpmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_adv,
    input  logic [7:0]  i_data_byte,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_idx, n_idx;
    logic [23:0] r_asm, n_asm;
    logic [31:0] r_id, n_id;
    logic [31:0] r_len, n_len;
    logic [31:0] r_check, n_check;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_magic;
    logic [31:0] rem_dec;
    logic [31:0] word;

    assign rem_dec = r_rem - 32'd1;
    assign word    = {i_data_byte, r_asm};

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_asm       = r_asm;
        n_id        = r_id;
        n_len       = r_len;
        n_check     = r_check;
        n_rem       = r_rem;
        o_res_valid = 1'b0;
        o_res.kind           = KIND_DATA;
        o_res.payload_byte   = 8'd0;
        o_res.last           = 1'b1;
        o_res.message_id     = r_id;
        o_res.message_length = r_len;
        o_res.check_value    = r_check;
        if (i_adv) begin
            unique case (r_phase)
                PH_DATA: begin
                    n_rem              = rem_dec;
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = i_data_byte;
                    o_res.last         = (rem_dec == 32'd0);
                    if (rem_dec == 32'd0) begin
                        n_phase = PH_ID;
                    end
                end
                default: begin
                    // unused codes fall back to the id phase
                    if (!(r_phase == PH_LEN || r_phase == PH_CHECK
                          || r_phase == PH_MAGIC)) begin
                        n_phase = PH_ID;
                    end
                    if (r_idx != LAST_HDR_BYTE) begin
                        n_idx = r_idx + 2'd1;
                        case (r_idx)
                            2'd0:    n_asm[7:0]   = i_data_byte;
                            2'd1:    n_asm[15:8]  = i_data_byte;
                            default: n_asm[23:16] = i_data_byte;
                        endcase
                    end else begin
                        n_idx = 2'd0;
                        n_asm = 24'd0;
                        case (r_phase)
                            PH_LEN: begin
                                n_len   = word;
                                n_phase = PH_CHECK;
                            end
                            PH_CHECK: begin
                                n_check = word;
                                n_phase = PH_MAGIC;
                            end
                            PH_MAGIC: begin
                                if (word != r_magic) begin
                                    o_res_valid = 1'b1;
                                    o_res.kind  = KIND_ERROR;
                                    n_phase     = PH_ID;
                                end else if (r_len == 32'd0) begin
                                    o_res_valid = 1'b1;
                                    o_res.kind  = KIND_EMPTY;
                                    n_phase     = PH_ID;
                                end else begin
                                    n_rem   = r_len;
                                    n_phase = PH_DATA;
                                end
                            end
                            default: begin
                                n_id    = word;
                                n_phase = PH_LEN;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ID;
            r_idx   <= 2'd0;
            r_asm   <= 24'd0;
            r_id    <= 32'd0;
            r_len   <= 32'd0;
            r_check <= 32'd0;
            r_rem   <= 32'd0;
            r_magic <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_asm   <= n_asm;
            r_id    <= n_id;
            r_len   <= n_len;
            r_check <= n_check;
            r_rem   <= n_rem;
            if (i_cfg_we) begin
                r_magic <= i_cfg_wdata;
            end
        end
    end

endmodule

>>> rtl/lpmd_out_stage.sv
// result register toward the downstream channel
// depends on lpmd_pkg
`timescale 1ns / 1ps

module lpmd_out_stage
    import lpmd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> rtl/lpmd_checker.sv
// port-level checks for the message deframer, bound to the top level
// depends on lpmd_pkg and the defines header
`timescale 1ns / 1ps
`include "length_prefixed_message_deframer_top_defines.svh"

module lpmd_checker
    import lpmd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_payload_byte,
    input logic        o_last,
    input logic [31:0] o_message_id
);

    `LPMD_ASSERT_RST(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

    `LPMD_ASSERT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_payload_byte) && $stable(o_message_id), "stalled result changed")

    `LPMD_ASSERT(a_end_last, i_clk, i_rst_n, o_valid && (o_kind == KIND_EMPTY || o_kind == KIND_ERROR) |-> o_last, "empty or error result without last")

    `LPMD_ASSERT(a_end_zero, i_clk, i_rst_n, o_valid && o_kind != KIND_DATA |-> o_payload_byte == 8'd0, "non-payload result carries a byte")

endmodule

bind length_prefixed_message_deframer_top lpmd_checker u_lpmd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_kind         (o_kind),
    .o_payload_byte (o_payload_byte),
    .o_last         (o_last),
    .o_message_id   (o_message_id)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for length_prefixed_message_deframer_top: byte stream in,
// deframed beats out, scoreboard against an in-bench predictor of the header parser
// depends on lpmd_pkg and the deframer rtl

module tb_top;
    import lpmd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_kind;
    logic [7:0]  o_payload_byte;
    logic        o_last;
    logic [31:0] o_message_id;
    logic [31:0] o_message_length;
    logic [31:0] o_check_value;

    length_prefixed_message_deframer_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last),
        .o_message_id     (o_message_id),
        .o_message_length (o_message_length),
        .o_check_value    (o_check_value)
    );

    // parser shadow state
    t_phase      parse_phase;
    logic [1:0]  hdr_idx;
    logic [31:0] word_acc;
    logic [31:0] held_id;
    logic [31:0] held_len;
    logic [31:0] held_check;
    logic [31:0] bytes_left;
    logic [31:0] magic_word;

    logic [7:0]  stream_bytes[$];
    t_result     deframed_beats[$];
    t_result     want;
    bit          byte_taken = 1'b0;
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic t_result make_beat(logic [1:0] kind, logic [7:0] data, logic last);
        t_result r;
        r.kind           = kind;
        r.payload_byte   = data;
        r.last           = last;
        r.message_id     = held_id;
        r.message_length = held_len;
        r.check_value    = held_check;
        return r;
    endfunction

    task automatic deframe_byte(input logic [7:0] data);
        logic [31:0] word;
        if (parse_phase == PH_DATA) begin
            bytes_left = bytes_left - 32'd1;
            deframed_beats.push_back(make_beat(KIND_DATA, data, bytes_left == 32'd0));
            if (bytes_left == 32'd0) parse_phase = PH_ID;
        end else begin
            word = word_acc | ({24'd0, data} << (8 * hdr_idx));
            if (hdr_idx != LAST_HDR_BYTE) begin
                word_acc = word;
                hdr_idx  = hdr_idx + 2'd1;
            end else begin
                word_acc = '0;
                hdr_idx  = '0;
                case (parse_phase)
                    PH_ID: begin
                        held_id     = word;
                        parse_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        held_len    = word;
                        parse_phase = PH_CHECK;
                    end
                    PH_CHECK: begin
                        held_check  = word;
                        parse_phase = PH_MAGIC;
                    end
                    default: begin
                        if (word != magic_word) begin
                            deframed_beats.push_back(make_beat(KIND_ERROR, 8'd0, 1'b1));
                            parse_phase = PH_ID;
                        end else if (held_len == 32'd0) begin
                            deframed_beats.push_back(make_beat(KIND_EMPTY, 8'd0, 1'b1));
                            parse_phase = PH_ID;
                        end else begin
                            bytes_left  = held_len;
                            parse_phase = PH_DATA;
                        end
                    end
                endcase
            end
        end
    endtask

    task automatic compare_field(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, exp_v, got_v);
            fail_count++;
        end
    endtask

    // byte acceptance feeds the predictor, then the output beat is scored
    always @(posedge i_clk) begin
        byte_taken = i_rst_n && i_valid && o_ready;
        if (byte_taken) deframe_byte(i_data_byte);
        if (i_rst_n && o_valid && i_ready) begin
            if (deframed_beats.size() == 0) begin
                $error("unexpected output beat: kind %0d id 0x%0h", o_kind, o_message_id);
                fail_count++;
            end else begin
                want = deframed_beats.pop_front();
                compare_field("kind", 32'(want.kind), 32'(o_kind));
                compare_field("payload_byte", 32'(want.payload_byte), 32'(o_payload_byte));
                compare_field("last", 32'(want.last), 32'(o_last));
                compare_field("message_id", want.message_id, o_message_id);
                compare_field("message_length", want.message_length, o_message_length);
                compare_field("check_value", want.check_value, o_check_value);
            end
        end
    end

    // byte driver and output backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (!i_valid || byte_taken) begin
                if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid     <= 1'b1;
                    i_data_byte <= stream_bytes.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic push_header_word(input logic [31:0] w);
        stream_bytes.push_back(w[7:0]);
        stream_bytes.push_back(w[15:8]);
        stream_bytes.push_back(w[23:16]);
        stream_bytes.push_back(w[31:24]);
    endtask

    task automatic queue_message(input logic [31:0] id, input logic [31:0] len,
                                 input logic [31:0] check, input logic [31:0] magic,
                                 input int payload_count);
        push_header_word(id);
        push_header_word(len);
        push_header_word(check);
        push_header_word(magic);
        for (int k = 0; k < payload_count; k++) stream_bytes.push_back(8'($urandom));
    endtask

    // mostly well-formed messages, some with a corrupted magic, some random headers
    task automatic queue_random_traffic(input int n_bytes);
        int          made;
        int          pick;
        logic [31:0] len;
        logic [31:0] bad;
        made = 0;
        while (made < n_bytes) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
                queue_message($urandom, len, $urandom, magic_word, int'(len));
                made += 16 + int'(len);
            end else begin
                if (pick <= 8) begin
                    bad = magic_word ^ (32'd1 << $urandom_range(0, 31));
                    len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 6) : $urandom;
                end else begin
                    bad = $urandom;
                    if (bad == magic_word) bad = ~bad;
                    len = $urandom;
                end
                queue_message($urandom, len, $urandom, bad, 0);
                made += 16;
            end
        end
    endtask

    task automatic wait_drained();
        while (stream_bytes.size() != 0 || i_valid || deframed_beats.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = 8'd0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 32'd0;
        i_ready     = 1'b0;
        parse_phase = PH_ID;
        hdr_idx     = '0;
        word_acc    = '0;
        held_id     = '0;
        held_len    = '0;
        held_check  = '0;
        bytes_left  = '0;
        magic_word  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 6; p++) begin
            case (p / 2)
                0: begin
                    send_idle_pct = 21;
                    recv_idle_pct = 86;
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (p > 0) begin
                @(negedge i_clk);
                case (p)
                    1:       i_cfg_wdata <= 32'hFFFF_FFFF;
                    3:       i_cfg_wdata <= 32'h0000_0000;
                    5:       i_cfg_wdata <= 32'hFFFF_0000;
                    default: i_cfg_wdata <= $urandom;
                endcase
                i_cfg_we <= 1'b1;
                @(posedge i_clk);
                magic_word = i_cfg_wdata;
                @(negedge i_clk);
                i_cfg_we <= 1'b0;
            end
            if (p == 0) begin
                // reset magic: empty message, short payload at byte extremes, bad magic
                queue_message(32'hFFFF_FFFF, 32'd0, 32'd0, magic_word, 0);
                push_header_word(32'd0);
                push_header_word(32'd2);
                push_header_word(32'hFFFF_FFFF);
                push_header_word(magic_word);
                stream_bytes.push_back(8'h00);
                stream_bytes.push_back(8'hFF);
                queue_message(32'h1234_5678, 32'd0, 32'hA5A5_5A5A, 32'h8000_0000, 0);
            end
            queue_random_traffic(200);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
